// ===== design/bmc_pkg.sv =====
`default_nettype none
package bmc_pkg;

  localparam int MAX_RELEVANT_BITS = 9;
  localparam int SQ_W              = 6;
  localparam int MAGIC_W           = 64;
  localparam int HALF_W            = MAGIC_W / 2;
  localparam int NBITS_W           = 4;
  localparam int HASH_W            = MAX_RELEVANT_BITS;
  localparam int MAP_DEPTH         = 1 << HASH_W;
  localparam int EPOCH_W           = 6;

  // One board square per subset bit, lowest subset bit first
  typedef logic [MAX_RELEVANT_BITS-1:0][SQ_W-1:0] bmc_tab_t;

  // Request from the sequencer to the visited map
  typedef struct packed {
    logic              new_item;
    logic              mark;
    logic [HASH_W-1:0] addr;
  } bmc_vreq_t;

  function automatic logic [2:0] bmc_min3(input logic [2:0] a, input logic [2:0] b);
    bmc_min3 = (a < b) ? a : b;
  endfunction

  // Ray lengths, interior squares only: up-right, down-left, up-left, down-right
  function automatic logic [3:0][2:0] bmc_rays(input logic [SQ_W-1:0] sq);
    logic [2:0] rank;
    logic [2:0] file;
    logic [2:0] up;
    logic [2:0] down;
    logic [2:0] left;
    logic [2:0] right;
    rank  = sq[5:3];
    file  = sq[2:0];
    up    = (rank <= 3'd6) ? 3'd6 - rank : 3'd0;
    down  = (rank >= 3'd1) ? rank - 3'd1 : 3'd0;
    right = (file <= 3'd6) ? 3'd6 - file : 3'd0;
    left  = (file >= 3'd1) ? file - 3'd1 : 3'd0;
    bmc_rays[0] = bmc_min3(up, right);
    bmc_rays[1] = bmc_min3(down, left);
    bmc_rays[2] = bmc_min3(up, left);
    bmc_rays[3] = bmc_min3(down, right);
  endfunction

  function automatic logic [NBITS_W-1:0] bmc_nbits(input logic [SQ_W-1:0] sq);
    logic [3:0][2:0] r;
    r = bmc_rays(sq);
    bmc_nbits = NBITS_W'(r[0]) + NBITS_W'(r[1]) + NBITS_W'(r[2]) + NBITS_W'(r[3]);
  endfunction

  // Square that each subset bit lands on, modulo the board size
  function automatic bmc_tab_t bmc_table(input logic [SQ_W-1:0] sq);
    logic [3:0][2:0] r;
    logic [3:0]      b1;
    logic [3:0]      b2;
    logic [3:0]      b3;
    logic [3:0]      kk;
    logic [SQ_W-1:0] step;
    r  = bmc_rays(sq);
    b1 = 4'(r[0]);
    b2 = b1 + 4'(r[1]);
    b3 = b2 + 4'(r[2]);
    for (int k = 0; k < MAX_RELEVANT_BITS; k++) begin
      kk = 4'(k);
      if (kk < b1) begin
        step = SQ_W'(kk - 4'd0) + SQ_W'(1);
        bmc_table[k] = sq + SQ_W'(9) * step;
      end else if (kk < b2) begin
        step = SQ_W'(kk - b1) + SQ_W'(1);
        bmc_table[k] = sq - SQ_W'(9) * step;
      end else if (kk < b3) begin
        step = SQ_W'(kk - b2) + SQ_W'(1);
        bmc_table[k] = sq + SQ_W'(7) * step;
      end else begin
        step = SQ_W'(kk - b3) + SQ_W'(1);
        bmc_table[k] = sq - SQ_W'(7) * step;
      end
    end
  endfunction

  // Spread a subset index over the ray squares
  function automatic logic [MAGIC_W-1:0] bmc_spread(input bmc_tab_t tab,
                                                     input logic [HASH_W-1:0] s);
    logic [MAGIC_W-1:0] occ;
    occ = '0;
    for (int k = 0; k < MAX_RELEVANT_BITS; k++) begin
      if (s[k]) begin
        occ[tab[k]] = 1'b1;
      end
    end
    bmc_spread = occ;
  endfunction

endpackage
`default_nettype wire

// ===== design/bmc_mul32.sv =====
`default_nettype none
module bmc_mul32
  import bmc_pkg::*;
(
  input  wire logic                  clk,
  input  wire logic [HALF_W-1:0]     a,
  input  wire logic [HALF_W-1:0]     b,
  output logic      [2*HALF_W-1:0]   p
);

  // Register the 32x32 product
  always_ff @(posedge clk) begin
    p <= (2*HALF_W)'(a) * (2*HALF_W)'(b);
  end

endmodule
`default_nettype wire

// ===== design/bmc_visit.sv =====
`default_nettype none
module bmc_visit
  import bmc_pkg::*;
(
  input  wire logic      clk,
  input  wire logic      rst,
  input  wire bmc_vreq_t req,
  output logic           hit,
  output logic           ready
);

  logic [EPOCH_W-1:0] mem [MAP_DEPTH];
  logic [EPOCH_W-1:0] rd_q;
  logic [EPOCH_W-1:0] epoch;
  logic               clr_busy;
  logic [HASH_W-1:0]  clr_addr;

  // Advance the epoch per item; sweep the map on wrap and after reset
  always_ff @(posedge clk) begin
    if (rst) begin
      epoch    <= EPOCH_W'(1);
      clr_busy <= 1'b1;
      clr_addr <= '0;
    end else begin
      if (clr_busy) begin
        clr_addr <= clr_addr + HASH_W'(1);
        if (clr_addr == {HASH_W{1'b1}}) begin
          clr_busy <= 1'b0;
        end
      end
      if (req.new_item) begin
        if (epoch == {EPOCH_W{1'b1}}) begin
          epoch    <= EPOCH_W'(1);
          clr_busy <= 1'b1;
          clr_addr <= '0;
        end else begin
          epoch <= epoch + EPOCH_W'(1);
        end
      end
    end
  end

  // Write the map: sweep clears, mark stamps the current epoch
  always_ff @(posedge clk) begin
    if (clr_busy) begin
      mem[clr_addr] <= '0;
    end else if (req.mark) begin
      mem[req.addr] <= epoch;
    end
  end

  // Read the map
  always_ff @(posedge clk) begin
    rd_q <= mem[req.addr];
  end

  assign hit   = (rd_q == epoch);
  assign ready = !clr_busy;

endmodule
`default_nettype wire

// ===== design/bishop_magic_collision_check.sv =====
`default_nettype none
// Tests a 64-bit candidate multiplier for one board square against every blocker
// subset on the square's four diagonal rays and returns is_valid and the relevant
// bit count n. Each subset passes through states MA, MB, MC, MD and CHK on one
// registered 32x32 multiplier (three partial products of the low 64 bits, hash, map
// read and check); an item finishes early on a collision. The visited map is a
// 512-entry memory tagged with a 6-bit epoch; after reset and once every 63 items a
// clearing pass runs before the subset loop starts. Input is taken only while the
// block is idle.
module bishop_magic_collision_check
  import bmc_pkg::*;
(
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        s_tvalid,
  output logic             s_tready,
  input  wire logic [71:0] s_tdata,   // [5:0] square_index, [69:6] candidate_multiplier
  output logic             m_tvalid,
  input  wire logic        m_tready,
  output logic [7:0]       m_tdata    // [0] is_valid, [4:1] relevant_bits
);

  localparam logic [2:0] ST_IDLE = 3'd0;
  localparam logic [2:0] ST_PREP = 3'd1;
  localparam logic [2:0] ST_MA   = 3'd2;
  localparam logic [2:0] ST_MB   = 3'd3;
  localparam logic [2:0] ST_MC   = 3'd4;
  localparam logic [2:0] ST_MD   = 3'd5;
  localparam logic [2:0] ST_CHK  = 3'd6;
  localparam logic [2:0] ST_DONE = 3'd7;

  logic [2:0]          state;
  bmc_tab_t            tab;
  logic [NBITS_W-1:0]  n_bits;
  logic [MAGIC_W-1:0]  magic;
  logic [HASH_W-1:0]   s;
  logic [HASH_W-1:0]   s_last;
  logic [MAGIC_W-1:0]  occ;
  logic [HALF_W-1:0]   acc;
  logic [HASH_W-1:0]   hash;
  logic                result_ok;
  logic [HALF_W-1:0]   mul_a;
  logic [HALF_W-1:0]   mul_b;
  logic [2*HALF_W-1:0] prod;
  logic [HALF_W-1:0]   high_sum;
  logic [NBITS_W-1:0]  shamt;
  logic [HASH_W-1:0]   hash_c;
  logic                hit;
  logic                map_ready;
  bmc_vreq_t           vreq;
  logic                in_fire;

  assign s_tready = (state == ST_IDLE);
  assign in_fire  = s_tvalid && s_tready;

  // Select operands for the shared multiplier
  always_comb begin
    case (state)
      ST_MB: begin
        mul_a = occ[HALF_W-1:0];
        mul_b = magic[MAGIC_W-1:HALF_W];
      end
      ST_MC: begin
        mul_a = occ[MAGIC_W-1:HALF_W];
        mul_b = magic[HALF_W-1:0];
      end
      default: begin
        mul_a = occ[HALF_W-1:0];
        mul_b = magic[HALF_W-1:0];
      end
    endcase
  end

  bmc_mul32 u_mul (
    .clk (clk),
    .a   (mul_a),
    .b   (mul_b),
    .p   (prod)
  );

  // Form the hash: top n bits of the low 64-bit product
  assign high_sum = acc + prod[HALF_W-1:0];
  assign shamt    = NBITS_W'(MAX_RELEVANT_BITS) - n_bits;
  assign hash_c   = high_sum[HALF_W-1 -: HASH_W] >> shamt;
  assign s_last   = HASH_W'(({{HASH_W{1'b0}}, 1'b1} << n_bits) - 1'b1);

  // Drive the visited map
  always_comb begin
    vreq.new_item = in_fire;
    vreq.mark     = (state == ST_CHK) && !hit;
    vreq.addr     = (state == ST_CHK) ? hash : hash_c;
  end

  bmc_visit u_visit (
    .clk   (clk),
    .rst   (rst),
    .req   (vreq),
    .hit   (hit),
    .ready (map_ready)
  );

  // Sequence the subsets
  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= ST_IDLE;
      m_tvalid <= 1'b0;
    end else begin
      if ((state == ST_DONE) && (!m_tvalid || m_tready)) begin
        m_tvalid <= 1'b1;
      end else if (m_tready) begin
        m_tvalid <= 1'b0;
      end
      case (state)
        ST_IDLE: begin
          if (in_fire) begin
            state <= ST_PREP;
          end
        end
        ST_PREP: begin
          if (map_ready) begin
            state <= ST_MA;
          end
        end
        ST_MA:  state <= ST_MB;
        ST_MB:  state <= ST_MC;
        ST_MC:  state <= ST_MD;
        ST_MD:  state <= ST_CHK;
        ST_CHK: begin
          if (hit || (s == s_last)) begin
            state <= ST_DONE;
          end else begin
            state <= ST_MA;
          end
        end
        ST_DONE: begin
          if (!m_tvalid || m_tready) begin
            state <= ST_IDLE;
          end
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

  // Hold item data, occupancy and partial sums
  always_ff @(posedge clk) begin
    case (state)
      ST_IDLE: begin
        if (in_fire) begin
          tab    <= bmc_table(s_tdata[SQ_W-1:0]);
          n_bits <= bmc_nbits(s_tdata[SQ_W-1:0]);
          magic  <= s_tdata[SQ_W +: MAGIC_W];
        end
      end
      ST_PREP: begin
        s   <= '0;
        occ <= '0;
      end
      ST_MB: begin
        acc <= prod[2*HALF_W-1:HALF_W];
      end
      ST_MC: begin
        acc <= high_sum;
      end
      ST_MD: begin
        hash <= hash_c;
      end
      ST_CHK: begin
        if (hit) begin
          result_ok <= 1'b0;
        end else if (s == s_last) begin
          result_ok <= 1'b1;
        end else begin
          s   <= s + HASH_W'(1);
          occ <= bmc_spread(tab, s + HASH_W'(1));
        end
      end
      default: begin
      end
    endcase
  end

  // Load the result beat
  always_ff @(posedge clk) begin
    if ((state == ST_DONE) && (!m_tvalid || m_tready)) begin
      m_tdata <= {3'b000, n_bits, result_ok};
    end
  end

endmodule
`default_nettype wire
